// ===== sv/apsc_pkg.sv =====
// ----------------------------------------------------------------------------
// apsc_pkg
// Shared types and constants for the aligned pair substitution counter.
// ----------------------------------------------------------------------------
package apsc_pkg;

   localparam int unsigned CNT_W   = 21;
   localparam int unsigned CHAR_W  = 8;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic [CHAR_W-1:0] CHAR_DASH = 8'h2D;  // '-'
   localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;  // '.'
   localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;  // 'A'
   localparam logic [CHAR_W-1:0] CHAR_C    = 8'h43;  // 'C'
   localparam logic [CHAR_W-1:0] CHAR_G    = 8'h47;  // 'G'
   localparam logic [CHAR_W-1:0] CHAR_T    = 8'h54;  // 'T'

   typedef enum logic {
      MODE_DNA     = 1'b0,
      MODE_PROTEIN = 1'b1
   } seq_mode_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_a;
      logic [CHAR_W-1:0] char_b;
      logic              last;
   } req_payload_type;

   typedef struct packed {
      logic [CNT_W-1:0] mismatches_or_transitions;
      logic [CNT_W-1:0] transversions;
      logic [CNT_W-1:0] compared_length;
   } rsp_payload_type;

   // Per-column increment decisions.
   typedef struct packed {
      logic inc_first;
      logic inc_second;
      logic inc_length;
   } col_class_type;

endpackage

// ===== sv/apsc_classify.sv =====
// ----------------------------------------------------------------------------
// apsc_classify
// Decides which counters one alignment column increments.
// ----------------------------------------------------------------------------
module apsc_classify (
   input  apsc_pkg::seq_mode_type          mode,
   input  logic [apsc_pkg::CHAR_W-1:0]     char_a,
   input  logic [apsc_pkg::CHAR_W-1:0]     char_b,
   output apsc_pkg::col_class_type         col_class
);
   import apsc_pkg::*;

   logic dna_gap;
   logic prot_gap;
   logic a_is_base;
   logic is_trans;
   logic differ;

   always_comb begin
      differ    = (char_a != char_b);
      dna_gap   = (char_a == CHAR_DASH) || (char_b == CHAR_DASH);
      prot_gap  = dna_gap || (char_a == CHAR_DOT) || (char_b == CHAR_DOT);
      a_is_base = (char_a == CHAR_A) || (char_a == CHAR_C) ||
                  (char_a == CHAR_G) || (char_a == CHAR_T);
      is_trans  = ((char_a == CHAR_A) && (char_b == CHAR_G)) ||
                  ((char_a == CHAR_G) && (char_b == CHAR_A)) ||
                  ((char_a == CHAR_C) && (char_b == CHAR_T)) ||
                  ((char_a == CHAR_T) && (char_b == CHAR_C));
      unique case (mode)
         MODE_DNA: begin
            col_class.inc_length = !dna_gap;
            col_class.inc_first  = !dna_gap && differ && a_is_base && is_trans;
            col_class.inc_second = !dna_gap && differ && a_is_base && !is_trans;
         end
         MODE_PROTEIN: begin
            col_class.inc_length = !prot_gap;
            col_class.inc_first  = !prot_gap && differ;
            col_class.inc_second = 1'b0;
         end
         default: begin
            col_class = '0;
         end
      endcase
   end

endmodule

// ===== sv/apsc_accum.sv =====
// ----------------------------------------------------------------------------
// apsc_accum
// Saturating column counters and the result register.
// ----------------------------------------------------------------------------
module apsc_accum #(
   parameter logic [20:0] SAT_LIMIT = 21'd1048576
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      col_valid,
   input  logic                      col_last,
   input  apsc_pkg::col_class_type   col_class,
   output logic                      col_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output apsc_pkg::rsp_payload_type rsp_data
);
   import apsc_pkg::*;

   logic [CNT_W-1:0] first_ff,  first_in;
   logic [CNT_W-1:0] second_ff, second_in;
   logic [CNT_W-1:0] len_ff,    len_in;
   logic [CNT_W-1:0] first_nxt, second_nxt, len_nxt;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff,  rsp_data_in;
   logic             col_take;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v,
                                                input logic            en);
      logic [CNT_W-1:0] r;
      r = v;
      if (en && (v < SAT_LIMIT)) begin
         r = v + 1'b1;
      end
      return r;
   endfunction

   // A last column needs room in the result register; others always pass.
   assign col_ready = !col_last || !rsp_valid_ff || rsp_ready;
   assign col_take  = col_valid && col_ready;

   always_comb begin
      first_nxt  = sat_inc(first_ff,  col_class.inc_first);
      second_nxt = sat_inc(second_ff, col_class.inc_second);
      len_nxt    = sat_inc(len_ff,    col_class.inc_length);

      first_in     = first_ff;
      second_in    = second_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (col_take) begin
         if (col_last) begin
            first_in     = '0;
            second_in    = '0;
            len_in       = '0;
            rsp_valid_in = 1'b1;
            rsp_data_in.mismatches_or_transitions = first_nxt;
            rsp_data_in.transversions             = second_nxt;
            rsp_data_in.compared_length           = len_nxt;
         end else begin
            first_in  = first_nxt;
            second_in = second_nxt;
            len_in    = len_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= '0;
         second_ff    <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         first_ff     <= first_in;
         second_ff    <= second_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Every mismatch column is also a compared column.
   a_first_le_len: assert property (@(posedge clock) disable iff (reset)
      (first_ff <= len_ff) && (second_ff <= len_ff))
      else $error("mismatch count exceeds compared length");

   a_len_saturates: assert property (@(posedge clock) disable iff (reset)
      len_ff <= SAT_LIMIT)
      else $error("length counter passed its saturation limit");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (col_take && col_last) |=> (rsp_valid_ff && (len_ff == '0)))
      else $error("last column did not produce a result and clear");

endmodule

// ===== sv/aligned_pair_substitution_counter_core.sv =====
// ----------------------------------------------------------------------------
// aligned_pair_substitution_counter_core
// Counts transitions/transversions (DNA) or mismatches (protein) over the
// columns of a pairwise alignment and emits the totals on the last column.
// ----------------------------------------------------------------------------
// Result path: an accepted last column passes through the input register, then
//    the counter update into the result register.
// Throughput: one column per cycle; the input register refills in the same
//    cycle it drains, and only a stalled result holds back a last column.
// Reset: synchronous, active high; clears counters, valid flags and sets the
//    mode register to DNA.
// ----------------------------------------------------------------------------
module aligned_pair_substitution_counter_core #(
   parameter longint unsigned MAX_COLUMNS = 1048576
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  apsc_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output apsc_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_data
);
   import apsc_pkg::*;

   // Counters stop at the smaller of the column limit and the field maximum.
   localparam logic [CNT_W-1:0] SAT_LIMIT =
      (MAX_COLUMNS < longint'(CNT_MAX)) ? CNT_W'(MAX_COLUMNS) : CNT_MAX;

   seq_mode_type    mode_ff,  mode_in;
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_data_ff,  s1_data_in;
   col_class_type   col_class;
   logic            col_ready;
   logic            s1_advance;

   // The mode register takes a transaction in every cycle. Only bit 0 of the
   // write data exists, so the value is taken as is.
   assign csr_ready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      if (csr_valid) begin
         mode_in = seq_mode_type'(csr_data);
      end
   end

   // Input register: a column moves on to the counters when the accumulator
   // can take it, and a new transaction is accepted in that same cycle.
   assign s1_advance = s1_valid_ff && col_ready;
   assign req_ready  = !s1_valid_ff || col_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff && !s1_advance;
      s1_data_in  = s1_data_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_DNA;
         s1_valid_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
   end

   // Column classification under the mode in force.
   apsc_classify u_classify (
      .mode      (mode_ff),
      .char_a    (s1_data_ff.char_a),
      .char_b    (s1_data_ff.char_b),
      .col_class (col_class)
   );

   // Saturating counters and the result register.
   apsc_accum #(
      .SAT_LIMIT (SAT_LIMIT)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .col_valid (s1_valid_ff),
      .col_last  (s1_data_ff.last),
      .col_class (col_class),
      .col_ready (col_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // A held column must stay put while the accumulator cannot take it.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !col_ready) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("input register lost a stalled column");

   // After reset nothing is in flight.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !rsp_valid))
      else $error("valid flags not cleared by reset");

endmodule
